>>> design/adtsd_pkg.sv
// ----------------------------------------------------------------------------
// adtsd_pkg
// Shared types and constants of the ADTS frame deframer: result kinds, error
// codes, the command queue entry and the sampling rate table.
// ----------------------------------------------------------------------------
package adtsd_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [31:0] CONST_MASK = 32'hfffe_fdc0;
   localparam logic [11:0] SYNC_WORD  = 12'hfff;
   localparam logic [3:0]  SFI_COUNT  = 4'd13;

   localparam logic [2:0] KIND_PAYLOAD = 3'd0;
   localparam logic [2:0] KIND_EMPTY   = 3'd1;
   localparam logic [2:0] KIND_INFO    = 3'd2;
   localparam logic [2:0] KIND_ERROR   = 3'd3;
   localparam logic [2:0] KIND_DONE    = 3'd4;

   localparam logic [2:0] ERR_SYNC    = 3'd0;
   localparam logic [2:0] ERR_LAYER   = 3'd1;
   localparam logic [2:0] ERR_FREQ    = 3'd2;
   localparam logic [2:0] ERR_CHAN    = 3'd3;
   localparam logic [2:0] ERR_SHORT   = 3'd4;
   localparam logic [2:0] ERR_RAW     = 3'd5;
   localparam logic [2:0] ERR_LOST    = 3'd6;

   typedef enum logic [2:0] {
      CMD_PAYLOAD    = 3'd0,
      CMD_EMPTY      = 3'd1,
      CMD_INFO       = 3'd2,
      CMD_INFO_EMPTY = 3'd3,
      CMD_ERROR      = 3'd4,
      CMD_DONE       = 3'd5
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] data;
      logic       last;
      logic [2:0] err;
      logic [1:0] profile;
      logic [3:0] sfi;
      logic [2:0] chan;
   } entry_type;

   function automatic logic [16:0] rate_hz(input logic [3:0] sfi);
      logic [16:0] r;
      unique case (sfi)
         4'd0:    r = 17'd96000;
         4'd1:    r = 17'd88200;
         4'd2:    r = 17'd64000;
         4'd3:    r = 17'd48000;
         4'd4:    r = 17'd44100;
         4'd5:    r = 17'd32000;
         4'd6:    r = 17'd24000;
         4'd7:    r = 17'd22050;
         4'd8:    r = 17'd16000;
         4'd9:    r = 17'd12000;
         4'd10:   r = 17'd11025;
         4'd11:   r = 17'd8000;
         4'd12:   r = 17'd7350;
         default: r = 17'd0;
      endcase
      return r;
   endfunction

endpackage

>>> design/adtsd_front.sv
// ----------------------------------------------------------------------------
// adtsd_front
// Byte parser: gathers and checks headers, skips CRC, counts body bytes and
// pushes at most one command per request into the queue.
// ----------------------------------------------------------------------------
module adtsd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic                req_kind,
   input  logic [7:0]          req_data_byte,
   input  logic                q_full,
   output logic                q_push,
   output adtsd_pkg::entry_type q_entry
);
   import adtsd_pkg::*;

   typedef enum logic [4:0] {
      PH_HDR  = 5'b00001,
      PH_CRC  = 5'b00010,
      PH_DATA = 5'b00100,
      PH_ERR  = 5'b01000,
      PH_DONE = 5'b10000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [2:0]  hcnt_ff, hcnt_in;
   logic        ccnt_ff, ccnt_in;
   logic [12:0] bcnt_ff, bcnt_in;
   logic [47:0] hbuf_ff, hbuf_in;
   logic [31:0] fhdr_ff, fhdr_in;
   logic        fseen_ff, fseen_in;
   logic [2:0]  err_ff, err_in;

   logic        accept;
   logic [55:0] hw;
   logic        crc;
   logic [12:0] flen;
   logic [12:0] hlen;
   logic [12:0] body;
   logic        hbad;
   logic [2:0]  hcode;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;
   assign hw       = {hbuf_ff, req_data_byte};
   assign crc      = !hw[40];
   assign flen     = hw[25:13];
   assign hlen     = crc ? 13'd9 : 13'd7;
   assign body     = flen - hlen;

   always_comb begin
      hbad  = 1'b1;
      hcode = ERR_SYNC;
      priority if (hw[55:44] != SYNC_WORD) begin
         hcode = ERR_SYNC;
      end else if (hw[42:41] != 2'd0) begin
         hcode = ERR_LAYER;
      end else if (hw[37:34] >= SFI_COUNT) begin
         hcode = ERR_FREQ;
      end else if (hw[32:30] == 3'd0) begin
         hcode = ERR_CHAN;
      end else if (flen < hlen) begin
         hcode = ERR_SHORT;
      end else if (hw[1:0] != 2'd0) begin
         hcode = ERR_RAW;
      end else if (fseen_ff && ((hw[55:24] & CONST_MASK) != (fhdr_ff & CONST_MASK))) begin
         hcode = ERR_LOST;
      end else begin
         hbad = 1'b0;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      hcnt_in  = hcnt_ff;
      ccnt_in  = ccnt_ff;
      bcnt_in  = bcnt_ff;
      hbuf_in  = hbuf_ff;
      fhdr_in  = fhdr_ff;
      fseen_in = fseen_ff;
      err_in   = err_ff;
      q_push   = 1'b0;
      q_entry         = '0;
      q_entry.cmd     = CMD_DONE;
      q_entry.profile = hw[39:38];
      q_entry.sfi     = hw[37:34];
      q_entry.chan    = hw[32:30];
      if (accept) begin
         if (phase_ff == PH_ERR) begin
            q_push      = 1'b1;
            q_entry.cmd = CMD_ERROR;
            q_entry.err = err_ff;
         end else if (phase_ff == PH_DONE || req_kind) begin
            q_push      = 1'b1;
            q_entry.cmd = CMD_DONE;
            phase_in    = PH_DONE;
         end else begin
            unique case (phase_ff)
               PH_HDR: begin
                  hbuf_in = {hbuf_ff[39:0], req_data_byte};
                  if (hcnt_ff != 3'd6) begin
                     hcnt_in = hcnt_ff + 3'd1;
                  end else begin
                     hcnt_in = 3'd0;
                     if (hbad) begin
                        q_push      = 1'b1;
                        q_entry.cmd = CMD_ERROR;
                        q_entry.err = hcode;
                        err_in      = hcode;
                        phase_in    = PH_ERR;
                     end else begin
                        bcnt_in = body;
                        if (!fseen_ff) begin
                           fseen_in    = 1'b1;
                           fhdr_in     = hw[55:24];
                           q_push      = 1'b1;
                           q_entry.cmd = CMD_INFO;
                        end
                        if (crc) begin
                           phase_in = PH_CRC;
                           ccnt_in  = 1'b0;
                        end else if (body == 13'd0) begin
                           q_push      = 1'b1;
                           q_entry.cmd = fseen_ff ? CMD_EMPTY : CMD_INFO_EMPTY;
                           q_entry.last = 1'b1;
                        end else begin
                           phase_in = PH_DATA;
                        end
                     end
                  end
               end
               PH_CRC: begin
                  if (!ccnt_ff) begin
                     ccnt_in = 1'b1;
                  end else if (bcnt_ff == 13'd0) begin
                     q_push       = 1'b1;
                     q_entry.cmd  = CMD_EMPTY;
                     q_entry.last = 1'b1;
                     phase_in     = PH_HDR;
                  end else begin
                     phase_in = PH_DATA;
                  end
               end
               PH_DATA: begin
                  q_push       = 1'b1;
                  q_entry.cmd  = CMD_PAYLOAD;
                  q_entry.data = req_data_byte;
                  if (bcnt_ff <= 13'd1) begin
                     q_entry.last = 1'b1;
                     phase_in     = PH_HDR;
                  end else begin
                     bcnt_in = bcnt_ff - 13'd1;
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR;
         hcnt_ff  <= 3'd0;
         ccnt_ff  <= 1'b0;
         bcnt_ff  <= 13'd0;
         fseen_ff <= 1'b0;
         err_ff   <= ERR_SYNC;
      end else begin
         phase_ff <= phase_in;
         hcnt_ff  <= hcnt_in;
         ccnt_ff  <= ccnt_in;
         bcnt_ff  <= bcnt_in;
         fseen_ff <= fseen_in;
         err_ff   <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      hbuf_ff <= hbuf_in;
      fhdr_ff <= fhdr_in;
   end

`ifndef ASSERT_OFF
   // errors and end of stream are terminal until reset
   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_ERR |=> phase_ff == PH_ERR)
      else $error("error phase left");
   a_data_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> bcnt_ff != 13'd0)
      else $error("body phase with zero count");
`endif

endmodule

>>> design/adtsd_queue.sv
// ----------------------------------------------------------------------------
// adtsd_queue
// Short command queue between the parser and the result stage.
// ----------------------------------------------------------------------------
module adtsd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  adtsd_pkg::entry_type wr_entry,
   output logic                 full,
   input  logic                 pop,
   output adtsd_pkg::entry_type rd_entry,
   output logic                 empty
);
   import adtsd_pkg::*;

   entry_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wptr_ff, wptr_in;
   logic [QPTR_W-1:0] rptr_ff, rptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_push;
   logic              do_pop;

   assign full     = cnt_ff == QCNT_W'(QUEUE_DEPTH);
   assign empty    = cnt_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign rd_entry = mem_ff[rptr_ff];

   always_comb begin
      wptr_in = do_push ? QPTR_W'(wptr_ff + 1'b1) : wptr_ff;
      rptr_in = do_pop ? QPTR_W'(rptr_ff + 1'b1) : rptr_ff;
      cnt_in  = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wptr_ff] <= wr_entry;
      end
   end

endmodule

>>> design/adtsd_back.sv
// ----------------------------------------------------------------------------
// adtsd_back
// Result stage: expands queued commands into result items, keeps the sample
// total and the stream info, and holds the result register.
// ----------------------------------------------------------------------------
module adtsd_back #(
   parameter int unsigned SAMPLES_PER_FRAME = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  adtsd_pkg::entry_type q_entry,
   input  logic                 q_empty,
   output logic                 q_pop,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [2:0]           rsp_out_kind,
   output logic [7:0]           rsp_payload_byte,
   output logic                 rsp_frame_last,
   output logic [47:0]          rsp_sample_total,
   output logic [2:0]           rsp_codec,
   output logic [2:0]           rsp_channels,
   output logic [16:0]          rsp_rate_hz,
   output logic [15:0]          rsp_asc_config,
   output logic [2:0]           rsp_error_code
);
   import adtsd_pkg::*;

   localparam logic [48:0] FRAME_ADD = 49'(SAMPLES_PER_FRAME);

   logic        valid_ff, valid_in;
   logic        half_ff, half_in;
   logic [47:0] samp_ff, samp_in;
   logic        iv_ff, iv_in;
   logic [1:0]  prof_ff, prof_in;
   logic [3:0]  sfi_ff, sfi_in;
   logic [2:0]  chan_ff, chan_in;

   logic [2:0]  kind_ff, kind_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic [47:0] tot_ff, tot_in;
   logic [2:0]  codec_ff, codec_in;
   logic [2:0]  chs_ff, chs_in;
   logic [16:0] rate_ff, rate_in;
   logic [15:0] asc_ff, asc_in;
   logic [2:0]  errc_ff, errc_in;

   logic        load;
   logic [48:0] sum;
   logic [47:0] sat;
   logic [2:0]  aot;

   assign load = !q_empty && (!valid_ff || rsp_pop);
   assign sum  = {1'b0, samp_ff} + FRAME_ADD;
   assign sat  = sum[48] ? '1 : sum[47:0];
   assign q_pop = load && !(q_entry.cmd == CMD_INFO_EMPTY && !half_ff);

   always_comb begin
      valid_in = valid_ff;
      half_in  = half_ff;
      samp_in  = samp_ff;
      iv_in    = iv_ff;
      prof_in  = prof_ff;
      sfi_in   = sfi_ff;
      chan_in  = chan_ff;
      kind_in  = kind_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      tot_in   = tot_ff;
      errc_in  = errc_ff;
      if (rsp_pop && valid_ff) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         byte_in  = 8'd0;
         last_in  = 1'b0;
         tot_in   = samp_ff;
         errc_in  = ERR_SYNC;
         half_in  = 1'b0;
         unique case (q_entry.cmd)
            CMD_PAYLOAD: begin
               kind_in = KIND_PAYLOAD;
               byte_in = q_entry.data;
               last_in = q_entry.last;
               tot_in  = sat;
               if (q_entry.last) begin
                  samp_in = sat;
               end
            end
            CMD_EMPTY: begin
               kind_in = KIND_EMPTY;
               last_in = 1'b1;
               tot_in  = sat;
               samp_in = sat;
            end
            CMD_INFO, CMD_INFO_EMPTY: begin
               if (q_entry.cmd == CMD_INFO_EMPTY && half_ff) begin
                  kind_in = KIND_EMPTY;
                  last_in = 1'b1;
                  tot_in  = sat;
                  samp_in = sat;
               end else begin
                  kind_in = KIND_INFO;
                  half_in = q_entry.cmd == CMD_INFO_EMPTY;
                  iv_in   = 1'b1;
                  prof_in = q_entry.profile;
                  sfi_in  = q_entry.sfi;
                  chan_in = q_entry.chan;
               end
            end
            CMD_ERROR: begin
               kind_in = KIND_ERROR;
               errc_in = q_entry.err;
            end
            CMD_DONE: begin
               kind_in = KIND_DONE;
            end
            default: begin
               kind_in = KIND_DONE;
            end
         endcase
      end
   end

   // stream info fields follow whatever info register holds after this load
   always_comb begin
      aot      = 3'({1'b0, prof_in} + 3'd1);
      codec_in = 3'd0;
      chs_in   = 3'd0;
      rate_in  = 17'd0;
      asc_in   = 16'd0;
      if (iv_in) begin
         codec_in = aot;
         chs_in   = chan_in;
         rate_in  = rate_hz(sfi_in);
         asc_in   = {2'b00, aot, sfi_in, 1'b0, chan_in, 3'd0};
      end
      if (!load) begin
         codec_in = codec_ff;
         chs_in   = chs_ff;
         rate_in  = rate_ff;
         asc_in   = asc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         half_ff  <= 1'b0;
         samp_ff  <= '0;
         iv_ff    <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         half_ff  <= half_in;
         samp_ff  <= samp_in;
         iv_ff    <= iv_in;
      end
   end

   always_ff @(posedge clock) begin
      prof_ff  <= prof_in;
      sfi_ff   <= sfi_in;
      chan_ff  <= chan_in;
      kind_ff  <= kind_in;
      byte_ff  <= byte_in;
      last_ff  <= last_in;
      tot_ff   <= tot_in;
      codec_ff <= codec_in;
      chs_ff   <= chs_in;
      rate_ff  <= rate_in;
      asc_ff   <= asc_in;
      errc_ff  <= errc_in;
   end

   assign rsp_empty        = !valid_ff;
   assign rsp_out_kind     = kind_ff;
   assign rsp_payload_byte = byte_ff;
   assign rsp_frame_last   = last_ff;
   assign rsp_sample_total = tot_ff;
   assign rsp_codec        = codec_ff;
   assign rsp_channels     = chs_ff;
   assign rsp_rate_hz      = rate_ff;
   assign rsp_asc_config   = asc_ff;
   assign rsp_error_code   = errc_ff;

`ifndef ASSERT_OFF
   a_half_head: assert property (@(posedge clock) disable iff (reset)
      half_ff |-> !q_empty && q_entry.cmd == CMD_INFO_EMPTY)
      else $error("split info request lost its queue entry");
   a_samp_mono: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> samp_ff >= $past(samp_ff))
      else $error("sample total went backward");
`endif

endmodule

>>> design/adts_frame_deframer.sv
// ----------------------------------------------------------------------------
// adts_frame_deframer
// ADTS byte stream deframer: checks frame headers, strips header and CRC and
// returns body bytes plus stream info, empty-frame, error and done results.
// ----------------------------------------------------------------------------
// Usage:
//   Request side is a queue write port: drive req_kind/req_data_byte and
//   raise req_push; the request is taken at a clock edge where req_full is
//   low. req_kind 1 marks end of stream.
//   Result side is a queue read port: while rsp_empty is low the oldest
//   result is on the rsp_ ports; raise rsp_pop to take it.
//   A taken request's command goes into the command queue; its first result
//   shows once the result register loads it. Throughput: one request and one
//   result per cycle while rsp_pop keeps up. The first valid header of a
//   frame without CRC and empty body gives two results; the four-entry
//   command queue between the parser and the result register absorbs this.
//   When rsp_pop stays low the result register holds, the command queue
//   fills, and req_full rises once it has four entries.
//   Reset clears the parser, the queue, the sample total and the stream
//   info; the block takes requests in the first cycle after reset.
// ----------------------------------------------------------------------------
module adts_frame_deframer #(
   parameter int unsigned SAMPLES_PER_FRAME = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_kind,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_out_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_frame_last,
   output logic [47:0] rsp_sample_total,
   output logic [2:0]  rsp_codec,
   output logic [2:0]  rsp_channels,
   output logic [16:0] rsp_rate_hz,
   output logic [15:0] rsp_asc_config,
   output logic [2:0]  rsp_error_code
);
   import adtsd_pkg::*;

   entry_type wr_entry;
   entry_type rd_entry;
   logic      q_push;
   logic      q_full;
   logic      q_pop;
   logic      q_empty;

   adtsd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_kind      (req_kind),
      .req_data_byte (req_data_byte),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_entry       (wr_entry)
   );

   adtsd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .wr_entry (wr_entry),
      .full     (q_full),
      .pop      (q_pop),
      .rd_entry (rd_entry),
      .empty    (q_empty)
   );

   adtsd_back #(
      .SAMPLES_PER_FRAME (SAMPLES_PER_FRAME)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_entry          (rd_entry),
      .q_empty          (q_empty),
      .q_pop            (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_out_kind     (rsp_out_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_frame_last   (rsp_frame_last),
      .rsp_sample_total (rsp_sample_total),
      .rsp_codec        (rsp_codec),
      .rsp_channels     (rsp_channels),
      .rsp_rate_hz      (rsp_rate_hz),
      .rsp_asc_config   (rsp_asc_config),
      .rsp_error_code   (rsp_error_code)
   );

endmodule

>>> verif/adts_frame_deframer_test.sv
// ----------------------------------------------------------------------------
// adts_frame_deframer_test
// Self-checking bench for the ADTS deframer. A short table of hand-built
// frames comes first, then random well-formed frames with random bodies and
// CRC use, and at the end either a truncated frame with end of stream or a
// header broken in one random way, followed by a few more requests. Every
// result is compared field by field with its table row or a behavioral stream parser.
// ----------------------------------------------------------------------------
module adts_frame_deframer_test;
   import adtsd_pkg::*;

   localparam int          FRAME_SAMPLES  = 1024;
   localparam int          HDR_BYTES      = 7;
   localparam int          CRC_BYTES      = 2;
   localparam int          MIN_LEN_PLAIN  = 7;
   localparam int          MIN_LEN_CRC    = 9;
   localparam int          RANDOM_ITEMS   = 1375;
   localparam int          ITEMS_PER_MODE = 350;
   localparam int          DRAIN_CYCLES   = 16;
   localparam int          WATCHDOG_LIMIT = 5000;
   localparam logic [2:0]  NO_ERROR       = 3'd0;

   // stream constants fixed by the first header
   localparam logic        DIR_ID      = 1'b1;
   localparam logic [1:0]  DIR_PROFILE = 2'd3;
   localparam logic [3:0]  DIR_SFI     = 4'd12;
   localparam logic [2:0]  DIR_CHAN    = 3'd7;
   localparam logic [2:0]  DIR_CODEC   = 3'd4;
   localparam logic [16:0] DIR_RATE    = 17'd7350;
   localparam logic [15:0] DIR_ASC     = 16'h2638;

   typedef enum logic [4:0] {
      PP_HEADER = 5'b00001,
      PP_CRC    = 5'b00010,
      PP_BODY   = 5'b00100,
      PP_ERROR  = 5'b01000,
      PP_DONE   = 5'b10000
   } parse_phase_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  payload;
      logic        last;
      logic [47:0] total;
      logic [2:0]  codec;
      logic [2:0]  chans;
      logic [16:0] rate;
      logic [15:0] asc;
      logic [2:0]  err;
   } result_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] data;
      logic [1:0] ntyped;
      result_type r0;
      result_type r1;
   } stim_row_type;

   logic        clock;
   logic        reset         = 1'b1;
   logic        req_push      = 1'b0;
   logic        req_kind      = 1'b0;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_pop       = 1'b0;
   logic        req_full;
   logic        rsp_empty;
   logic [2:0]  rsp_out_kind;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_frame_last;
   logic [47:0] rsp_sample_total;
   logic [2:0]  rsp_codec;
   logic [2:0]  rsp_channels;
   logic [16:0] rsp_rate_hz;
   logic [15:0] rsp_asc_config;
   logic [2:0]  rsp_error_code;

   // parser state
   parse_phase_type pp          = PP_HEADER;
   logic [12:0]     byte_cnt    = '0;
   logic [55:0]     hdr_buf     = '0;
   logic [31:0]     first_hdr   = '0;
   logic            first_seen  = 1'b0;
   logic [12:0]     frame_len   = '0;
   logic            crc_present = 1'b0;
   logic [47:0]     samples     = '0;
   logic [2:0]      err_latched = NO_ERROR;

   result_type   step_out [0:1];
   int           step_n;
   result_type   parsed_results [$];
   stim_row_type frame_table [$];
   result_type   popped;

   int    send_idle_pct = 0;
   int    rsp_stall_pct = 0;
   int    items_sent    = 0;
   int    results_seen  = 0;
   int    frames_seen   = 0;
   int    failures      = 0;
   int    quiet_cycles  = 0;
   string stream_end    = "";

   adts_frame_deframer u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_kind         (req_kind),
      .req_data_byte    (req_data_byte),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_out_kind     (rsp_out_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_frame_last   (rsp_frame_last),
      .rsp_sample_total (rsp_sample_total),
      .rsp_codec        (rsp_codec),
      .rsp_channels     (rsp_channels),
      .rsp_rate_hz      (rsp_rate_hz),
      .rsp_asc_config   (rsp_asc_config),
      .rsp_error_code   (rsp_error_code)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------ parser

   function automatic logic [16:0] rate_of(input logic [3:0] sfi);
      case (sfi)
         4'd0:    return 17'd96000;
         4'd1:    return 17'd88200;
         4'd2:    return 17'd64000;
         4'd3:    return 17'd48000;
         4'd4:    return 17'd44100;
         4'd5:    return 17'd32000;
         4'd6:    return 17'd24000;
         4'd7:    return 17'd22050;
         4'd8:    return 17'd16000;
         4'd9:    return 17'd12000;
         4'd10:   return 17'd11025;
         4'd11:   return 17'd8000;
         4'd12:   return 17'd7350;
         default: return 17'd0;
      endcase
   endfunction

   function automatic logic [47:0] plus_frame(input logic [47:0] s);
      logic [48:0] sum;
      sum = {1'b0, s} + 49'(FRAME_SAMPLES);
      return sum[48] ? {48{1'b1}} : sum[47:0];
   endfunction

   task automatic emit(input logic [2:0] kind, input logic [7:0] b, input logic last,
                       input logic [47:0] total, input logic [2:0] err);
      result_type r;
      r = '0;
      r.kind    = kind;
      r.payload = b;
      r.last    = last;
      r.total   = total;
      r.err     = err;
      if (first_seen) begin
         r.codec = {1'b0, first_hdr[15:14]} + 3'd1;
         r.chans = first_hdr[8:6];
         r.rate  = rate_of(first_hdr[13:10]);
         r.asc   = {2'b00, r.codec, first_hdr[13:10], 1'b0, first_hdr[8:6], 3'b000};
      end
      step_out[step_n] = r;
      step_n++;
   endtask

   task automatic start_body();
      logic [12:0] body;
      body = 13'(frame_len - HDR_BYTES - (crc_present ? CRC_BYTES : 0));
      if (body == 13'd0) begin
         samples = plus_frame(samples);
         emit(KIND_EMPTY, 8'h00, 1'b1, samples, NO_ERROR);
         pp       = PP_HEADER;
         byte_cnt = '0;
      end else begin
         pp       = PP_BODY;
         byte_cnt = body;
      end
   endtask

   task automatic parse_stream_item(input logic k, input logic [7:0] b);
      logic       bad;
      logic [2:0] code;
      step_n = 0;
      code   = NO_ERROR;
      if (pp == PP_ERROR) begin
         emit(KIND_ERROR, 8'h00, 1'b0, samples, err_latched);
      end else if (pp == PP_DONE || k) begin
         pp = PP_DONE;
         emit(KIND_DONE, 8'h00, 1'b0, samples, NO_ERROR);
      end else if (pp == PP_HEADER) begin
         hdr_buf  = {hdr_buf[47:0], b};
         byte_cnt = byte_cnt + 13'd1;
         if (byte_cnt == HDR_BYTES) begin
            byte_cnt = '0;
            bad      = 1'b1;
            if (hdr_buf[55:44] != SYNC_WORD)
               code = ERR_SYNC;
            else if (hdr_buf[42:41] != 2'd0)
               code = ERR_LAYER;
            else if (hdr_buf[37:34] >= SFI_COUNT)
               code = ERR_FREQ;
            else if (hdr_buf[32:30] == 3'd0)
               code = ERR_CHAN;
            else if (hdr_buf[25:13] < (hdr_buf[40] ? MIN_LEN_PLAIN : MIN_LEN_CRC))
               code = ERR_SHORT;
            else if (hdr_buf[1:0] != 2'd0)
               code = ERR_RAW;
            else if (first_seen &&
                     ((hdr_buf[55:24] & CONST_MASK) != (first_hdr & CONST_MASK)))
               code = ERR_LOST;
            else
               bad = 1'b0;
            if (bad) begin
               err_latched = code;
               pp          = PP_ERROR;
               emit(KIND_ERROR, 8'h00, 1'b0, samples, err_latched);
            end else begin
               frame_len   = hdr_buf[25:13];
               crc_present = !hdr_buf[40];
               if (!first_seen) begin
                  first_hdr  = hdr_buf[55:24];
                  first_seen = 1'b1;
                  emit(KIND_INFO, 8'h00, 1'b0, samples, NO_ERROR);
               end
               if (crc_present) begin
                  pp       = PP_CRC;
                  byte_cnt = '0;
               end else begin
                  start_body();
               end
            end
         end
      end else if (pp == PP_CRC) begin
         byte_cnt = byte_cnt + 13'd1;
         if (byte_cnt == CRC_BYTES)
            start_body();
      end else if (byte_cnt <= 13'd1) begin
         samples = plus_frame(samples);
         emit(KIND_PAYLOAD, b, 1'b1, samples, NO_ERROR);
         pp       = PP_HEADER;
         byte_cnt = '0;
      end else begin
         emit(KIND_PAYLOAD, b, 1'b0, plus_frame(samples), NO_ERROR);
         byte_cnt = byte_cnt - 13'd1;
      end
   endtask

   // --------------------------------------------------------------- stimulus

   function automatic logic [55:0] adts_header(
      input logic prot_absent, input logic id, input logic [1:0] layer,
      input logic [1:0] profile, input logic [3:0] sfi, input logic priv,
      input logic [2:0] chan, input logic [3:0] misc, input logic [12:0] len,
      input logic [10:0] fullness, input logic [1:0] raw);
      return {SYNC_WORD, id, layer, prot_absent, profile, sfi, priv, chan, misc,
              len, fullness, raw};
   endfunction

   function automatic result_type typed_result(input logic [2:0] kind, input logic [7:0] b,
                                               input logic last, input logic [47:0] total);
      result_type r;
      r         = '0;
      r.kind    = kind;
      r.payload = b;
      r.last    = last;
      r.total   = total;
      r.codec   = DIR_CODEC;
      r.chans   = DIR_CHAN;
      r.rate    = DIR_RATE;
      r.asc     = DIR_ASC;
      r.err     = NO_ERROR;
      return r;
   endfunction

   task automatic add_row(input logic k, input logic [7:0] b, input logic [1:0] ntyped,
                          input result_type r0, input result_type r1);
      stim_row_type row;
      row.kind   = k;
      row.data   = b;
      row.ntyped = ntyped;
      row.r0     = r0;
      row.r1     = r1;
      frame_table.push_back(row);
   endtask

   task automatic add_header_rows(input logic [55:0] hdr, input logic [1:0] ntyped,
                                  input result_type r0, input result_type r1);
      for (int i = 0; i < HDR_BYTES - 1; i++)
         add_row(1'b0, hdr[55 - 8 * i -: 8], 2'd0, '0, '0);
      add_row(1'b0, hdr[7:0], ntyped, r0, r1);
   endtask

   task automatic issue(input logic k, input logic [7:0] b, input logic [1:0] ntyped,
                        input result_type r0, input result_type r1);
      case (items_sent / ITEMS_PER_MODE)
         0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
         1: begin send_idle_pct = 61; rsp_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  rsp_stall_pct = 61; end
         default: begin send_idle_pct = 11; rsp_stall_pct = 11; end
      endcase
      if ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_push      <= 1'b1;
      req_kind      <= k;
      req_data_byte <= b;
      do @(posedge clock); while (req_full);
      items_sent++;
      parse_stream_item(k, b);
      if (ntyped == 2'd0) begin
         for (int i = 0; i < step_n; i++)
            parsed_results.push_back(step_out[i]);
      end else begin
         parsed_results.push_back(r0);
         if (ntyped == 2'd2)
            parsed_results.push_back(r1);
      end
   endtask

   // sends the first nbytes of a frame: header, then random CRC/body bytes
   task automatic send_frame(input logic [55:0] hdr, input int nbytes);
      for (int i = 0; i < nbytes; i++) begin
         if (i < HDR_BYTES)
            issue(1'b0, hdr[55 - 8 * i -: 8], 2'd0, '0, '0);
         else
            issue(1'b0, 8'($urandom_range(255)), 2'd0, '0, '0);
      end
   endtask

   // ---------------------------------------------------------------- checking

   task automatic check_field(input string name, input logic [47:0] want,
                              input logic [47:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         results_seen++;
         if (parsed_results.size() == 0) begin
            $error("result of kind %0d with no request pending", rsp_out_kind);
            failures++;
         end else begin
            popped = parsed_results.pop_front();
            if (popped.last)
               frames_seen++;
            check_field("out_kind", popped.kind, rsp_out_kind);
            check_field("payload_byte", popped.payload, rsp_payload_byte);
            check_field("frame_last", popped.last, rsp_frame_last);
            check_field("sample_total", popped.total, rsp_sample_total);
            check_field("codec", popped.codec, rsp_codec);
            check_field("channels", popped.chans, rsp_channels);
            check_field("rate_hz", popped.rate, rsp_rate_hz);
            check_field("asc_config", popped.asc, rsp_asc_config);
            check_field("error_code", popped.err, rsp_error_code);
         end
      end
      rsp_pop <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $error("no request or result moved for %0d cycles", WATCHDOG_LIMIT);
         $display("** adts_frame_deframer: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------- main

   initial begin
      logic        crc;
      logic        prot;
      logic        id;
      logic [1:0]  layer;
      logic [1:0]  profile;
      logic [3:0]  sfi;
      logic [2:0]  chan;
      logic [12:0] len;
      logic [1:0]  raw;
      logic [2:0]  fault;
      logic [55:0] hdr;
      int          body;

      // first header: no CRC, empty body -> stream info then empty frame
      add_header_rows(adts_header(1'b1, DIR_ID, 2'd0, DIR_PROFILE, DIR_SFI, 1'b0,
                                  DIR_CHAN, 4'h0, 13'd7, 11'd0, 2'd0), 2'd2,
                      typed_result(KIND_INFO, 8'h00, 1'b0, 48'd0),
                      typed_result(KIND_EMPTY, 8'h00, 1'b1, 48'd1024));
      // CRC frame with empty body, free header bits all set
      add_header_rows(adts_header(1'b0, DIR_ID, 2'd0, DIR_PROFILE, DIR_SFI, 1'b1,
                                  DIR_CHAN, 4'hf, 13'd9, 11'h7ff, 2'd0), 2'd0, '0, '0);
      add_row(1'b0, 8'h00, 2'd0, '0, '0);
      add_row(1'b0, 8'hff, 2'd1, typed_result(KIND_EMPTY, 8'h00, 1'b1, 48'd2048), '0);
      // two-byte body, no CRC
      add_header_rows(adts_header(1'b1, DIR_ID, 2'd0, DIR_PROFILE, DIR_SFI, 1'b0,
                                  DIR_CHAN, 4'ha, 13'd9, 11'h155, 2'd0), 2'd0, '0, '0);
      add_row(1'b0, 8'h00, 2'd1, typed_result(KIND_PAYLOAD, 8'h00, 1'b0, 48'd3072), '0);
      add_row(1'b0, 8'hff, 2'd1, typed_result(KIND_PAYLOAD, 8'hff, 1'b1, 48'd3072), '0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < frame_table.size(); i++)
         issue(frame_table[i].kind, frame_table[i].data, frame_table[i].ntyped,
               frame_table[i].r0, frame_table[i].r1);

      while (items_sent < RANDOM_ITEMS) begin
         crc  = 1'($urandom_range(1));
         body = ($urandom_range(29) == 0) ? $urandom_range(700, 100) : $urandom_range(24);
         len  = 13'(HDR_BYTES + (crc ? CRC_BYTES : 0) + body);
         hdr  = adts_header(!crc, DIR_ID, 2'd0, DIR_PROFILE, DIR_SFI, 1'($urandom_range(1)),
                            DIR_CHAN, 4'($urandom_range(15)), len,
                            11'($urandom_range(2047)), 2'd0);
         send_frame(hdr, len);
      end

      // stream end: truncated frame and end of stream, or one broken header
      prot    = 1'($urandom_range(1));
      id      = DIR_ID;
      layer   = 2'd0;
      profile = DIR_PROFILE;
      sfi     = DIR_SFI;
      chan    = DIR_CHAN;
      len     = 13'($urandom_range(40, MIN_LEN_CRC));
      raw     = 2'd0;
      if ($urandom_range(1) == 0) begin
         hdr = adts_header(prot, id, layer, profile, sfi, 1'b0, chan, 4'h5, len,
                           11'h2aa, raw);
         send_frame(hdr, $urandom_range(len - 1));
         issue(1'b1, 8'($urandom_range(255)), 2'd0, '0, '0);
         stream_end = "end of stream";
      end else begin
         fault = 3'($urandom_range(6));
         case (fault)
            ERR_LAYER: layer = 2'($urandom_range(3, 1));
            ERR_FREQ:  sfi   = 4'($urandom_range(15, 13));
            ERR_CHAN:  chan  = 3'd0;
            ERR_SHORT: len   = 13'($urandom_range(prot ? MIN_LEN_PLAIN - 1 : MIN_LEN_CRC - 1));
            ERR_RAW:   raw   = 2'($urandom_range(3, 1));
            ERR_LOST: begin
               if ($urandom_range(1) == 0)
                  id = !id;
               else
                  profile = profile + 2'd1;
            end
            default: ;
         endcase
         hdr = adts_header(prot, id, layer, profile, sfi, 1'b0, chan, 4'h5, len,
                           11'h2aa, raw);
         if (fault == ERR_SYNC)
            hdr[55:44] = hdr[55:44] ^ 12'($urandom_range(4095, 1));
         send_frame(hdr, HDR_BYTES);
         issue(1'b1, 8'($urandom_range(255)), 2'd0, '0, '0);
         $sformat(stream_end, "header error %0d", fault);
      end
      repeat (3)
         issue(1'($urandom_range(1)), 8'($urandom_range(255)), 2'd0, '0, '0);
      req_push <= 1'b0;

      while (parsed_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run: %0d requests, %0d results, %0d frames closed, stream rate %0d Hz",
               items_sent, results_seen, frames_seen, DIR_RATE);
      $display("run: idle/stall modes all visited, stream closed by %s", stream_end);
      if (failures == 0)
         $display("** adts_frame_deframer: PASSED **");
      else
         $display("** adts_frame_deframer: FAILED **");
      $finish;
   end

endmodule

>>> sim.f
design/adtsd_pkg.sv
design/adtsd_front.sv
design/adtsd_queue.sv
design/adtsd_back.sv
design/adts_frame_deframer.sv
verif/adts_frame_deframer_test.sv
